// ===== rtl/core/pps_pkg.sv =====
// pps_pkg: shared types and constants of the priority scheduler
// task table entry layout, command codes, field widths
// no dependencies
package pps_pkg;

    localparam int TIME_W            = 16;
    localparam int PRIO_W            = 8;
    localparam int IDX_W             = 3;
    localparam int CMD_W             = 2;
    localparam int CNT_W             = 4;
    localparam int DEFAULT_PROCESSES = 8;

    localparam logic [TIME_W-1:0] TIME_MAX     = '1;
    localparam logic [CNT_W-1:0]  PCOUNT_RESET = 4'd8;

    // command codes of an input item
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // one task table entry as kept in the entry memory
    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remaining;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] completion;
    } t_entry;

endpackage

// ===== rtl/core/pps_entry_ram.sv =====
// pps_entry_ram: task table memory, one write port and one read port
// read data is registered
// depends on pps_pkg for the entry type
module pps_entry_ram
    import pps_pkg::*;
#(
    parameter int DEPTH = DEFAULT_PROCESSES,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/preemptive_priority_scheduler_unit.sv =====
// preemptive_priority_scheduler_unit: top level of the task scheduler, uses pps_pkg, pps_entry_ram
// a tick scans the n entries in use, one memory read per entry
// one item at a time; the next item is taken the cycle after its result enters the output
// register; a result waits while the output register holds a stalled result
// reset (synchronous, active low) clears time, marks every entry finished, process_count to 8
module preemptive_priority_scheduler_unit
    import pps_pkg::*;
#(
    parameter int PROCESSES = DEFAULT_PROCESSES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // item input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic [TIME_W-1:0] i_arrival_time,
    input  logic [TIME_W-1:0] i_burst_length,
    input  logic [PRIO_W-1:0] i_priority_level,
    // result output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [IDX_W-1:0]  o_selected_index,
    output logic              o_idle_tick,
    output logic              o_task_finished,
    output logic              o_all_finished,
    output logic [TIME_W-1:0] o_current_time,
    output logic              o_entry_done,
    output logic [TIME_W-1:0] o_completion_time,
    output logic [TIME_W-1:0] o_turnaround_time,
    output logic [TIME_W-1:0] o_waiting_time,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data
);

    localparam int AW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int CW = $clog2(PROCESSES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_UPDATE,
        S_QREAD,
        S_QCALC,
        S_RESULT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_proc_count;
    logic [TIME_W-1:0]   r_time;
    logic [PROCESSES-1:0] r_done_flags;

    // captured item
    logic [AW-1:0]       r_idx;
    logic                r_idx_ok;
    logic [TIME_W-1:0]   r_arrival;
    logic [TIME_W-1:0]   r_burst;
    logic [PRIO_W-1:0]   r_prio;

    // scan state
    logic [CW-1:0]       r_scan_addr;
    logic                r_scan_pend;
    logic [AW-1:0]       r_pend_idx;
    logic                r_found;
    logic [AW-1:0]       r_best_idx;
    t_entry              r_best;

    // result being built
    logic [IDX_W-1:0]    r_res_sel;
    logic                r_res_idle;
    logic                r_res_fin;
    logic                r_res_edone;
    logic [TIME_W-1:0]   r_res_ct;
    logic [TIME_W-1:0]   r_res_tat;
    logic [TIME_W-1:0]   r_res_wt;

    // output register
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_sel;
    logic                r_out_idle;
    logic                r_out_fin;
    logic                r_out_allfin;
    logic [TIME_W-1:0]   r_out_time;
    logic                r_out_edone;
    logic [TIME_W-1:0]   r_out_ct;
    logic [TIME_W-1:0]   r_out_tat;
    logic [TIME_W-1:0]   r_out_wt;

    logic                w_in_xfer;
    logic                w_out_free;
    logic [CW-1:0]       w_in_use;
    logic [PROCESSES-1:0] w_use_mask;
    logic                w_all_fin;
    logic                w_idx_ok;
    logic [AW-1:0]       w_idx;
    t_entry              w_rdata;
    logic                w_mem_we;
    logic [AW-1:0]       w_mem_waddr;
    t_entry              w_mem_wdata;
    logic                w_mem_re;
    logic [AW-1:0]       w_mem_raddr;
    logic                w_ready;
    logic                w_better;
    logic [TIME_W-1:0]   w_rem_new;
    logic [TIME_W-1:0]   w_time_inc;
    t_entry              w_upd;
    logic [TIME_W-1:0]   w_tat;
    logic [TIME_W-1:0]   w_wt;

    // handshakes
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // entries in use, limited to the table size
    assign w_in_use = ({3'b000, r_proc_count} > 7'(PROCESSES)) ? CW'(PROCESSES)
                                                              : CW'(r_proc_count);

    // all entries in use have finished
    always_comb begin
        for (int i = 0; i < PROCESSES; i++) begin
            w_use_mask[i] = (i < int'(w_in_use));
        end
    end
    assign w_all_fin = &(r_done_flags | ~w_use_mask);

    // input index decode
    assign w_idx_ok = ({4'b0000, i_entry_index} < 7'(PROCESSES));
    assign w_idx    = AW'(i_entry_index);

    // saturating time step
    assign w_time_inc = (r_time == TIME_MAX) ? TIME_MAX : r_time + 16'd1;

    // candidate check on returned scan data
    assign w_ready  = (w_rdata.arrival <= r_time) && (w_rdata.remaining != '0);
    assign w_better = !r_found || (w_rdata.prio < r_best.prio);

    // read-modify-write of the winning entry
    assign w_rem_new = r_best.remaining - 16'd1;
    always_comb begin
        w_upd           = r_best;
        w_upd.remaining = w_rem_new;
        if (w_rem_new == '0) begin
            w_upd.completion = w_time_inc;
        end
    end

    // query arithmetic with clamping at zero
    assign w_tat = (w_rdata.completion > w_rdata.arrival)
                   ? w_rdata.completion - w_rdata.arrival : '0;
    assign w_wt  = (w_tat > w_rdata.burst) ? w_tat - w_rdata.burst : '0;

    // memory port control
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_idx;
        w_mem_wdata = w_upd;
        w_mem_re    = 1'b0;
        w_mem_raddr = r_idx;
        case (r_state)
            S_LOAD: begin
                w_mem_we    = r_idx_ok;
                w_mem_wdata = '{arrival: r_arrival, burst: r_burst, remaining: r_burst,
                                prio: r_prio, completion: '0};
            end
            S_UPDATE: begin
                w_mem_we    = r_found;
                w_mem_waddr = r_best_idx;
            end
            S_SCAN: begin
                w_mem_re    = (r_scan_addr < w_in_use);
                w_mem_raddr = r_scan_addr[AW-1:0];
            end
            S_QREAD: begin
                w_mem_re    = r_idx_ok;
            end
            default: begin
            end
        endcase
    end

    pps_entry_ram #(
        .DEPTH (PROCESSES),
        .AW    (AW)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_rdata)
    );

    // sequencer, scheduler state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_proc_count <= PCOUNT_RESET;
            r_time       <= '0;
            r_done_flags <= '1;
            r_out_valid  <= 1'b0;
            r_scan_pend  <= 1'b0;
            r_found      <= 1'b0;
        end else begin
            // configuration transfer
            if (i_cfg_valid && o_cfg_ready) begin
                r_proc_count <= i_cfg_data;
            end

            // output register valid: set on load, cleared on drain
            if ((r_state == S_RESULT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_idx       <= w_idx;
                        r_idx_ok    <= w_idx_ok;
                        r_arrival   <= i_arrival_time;
                        r_burst     <= i_burst_length;
                        r_prio      <= i_priority_level;
                        r_res_sel   <= '0;
                        r_res_idle  <= 1'b0;
                        r_res_fin   <= 1'b0;
                        r_res_edone <= 1'b0;
                        r_res_ct    <= '0;
                        r_res_tat   <= '0;
                        r_res_wt    <= '0;
                        r_scan_addr <= '0;
                        r_scan_pend <= 1'b0;
                        r_found     <= 1'b0;
                        case (t_cmd'(i_command))
                            CMD_LOAD:  r_state <= S_LOAD;
                            CMD_TICK:  r_state <= S_SCAN;
                            CMD_QUERY: r_state <= S_QREAD;
                            default:   r_state <= S_RESULT;
                        endcase
                    end
                end
                S_LOAD: begin
                    if (r_idx_ok) begin
                        r_done_flags[r_idx] <= (r_burst == '0);
                    end
                    r_state <= S_RESULT;
                end
                S_SCAN: begin
                    // evaluate the entry read last cycle
                    if (r_scan_pend && w_ready && w_better) begin
                        r_found    <= 1'b1;
                        r_best_idx <= r_pend_idx;
                        r_best     <= w_rdata;
                    end
                    // issue the next read
                    if (r_scan_addr < w_in_use) begin
                        r_scan_pend <= 1'b1;
                        r_pend_idx  <= r_scan_addr[AW-1:0];
                        r_scan_addr <= r_scan_addr + 1'b1;
                    end else begin
                        r_scan_pend <= 1'b0;
                        if (!r_scan_pend) begin
                            r_state <= S_UPDATE;
                        end
                    end
                end
                S_UPDATE: begin
                    if (r_found) begin
                        r_res_sel                 <= IDX_W'(r_best_idx);
                        r_res_fin                 <= (w_rem_new == '0);
                        r_done_flags[r_best_idx]  <= (w_rem_new == '0);
                    end else begin
                        r_res_idle <= 1'b1;
                    end
                    r_time  <= w_time_inc;
                    r_state <= S_RESULT;
                end
                S_QREAD: begin
                    r_state <= S_QCALC;
                end
                S_QCALC: begin
                    if (r_idx_ok && (w_rdata.remaining == '0)) begin
                        r_res_edone <= 1'b1;
                        r_res_ct    <= w_rdata.completion;
                        r_res_tat   <= w_tat;
                        r_res_wt    <= w_wt;
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (w_out_free) begin
                        r_out_sel    <= r_res_sel;
                        r_out_idle   <= r_res_idle;
                        r_out_fin    <= r_res_fin;
                        r_out_allfin <= w_all_fin;
                        r_out_time   <= r_time;
                        r_out_edone  <= r_res_edone;
                        r_out_ct     <= r_res_ct;
                        r_out_tat    <= r_res_tat;
                        r_out_wt     <= r_res_wt;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result ports
    assign o_out_valid       = r_out_valid;
    assign o_selected_index  = r_out_sel;
    assign o_idle_tick       = r_out_idle;
    assign o_task_finished   = r_out_fin;
    assign o_all_finished    = r_out_allfin;
    assign o_current_time    = r_out_time;
    assign o_entry_done      = r_out_edone;
    assign o_completion_time = r_out_ct;
    assign o_turnaround_time = r_out_tat;
    assign o_waiting_time    = r_out_wt;

    // scan never runs past the entries in use
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan_addr <= w_in_use))
        else $error("scan address beyond entries in use");

    // a finishing task means the tick was not idle
    a_fin_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fin) |-> !r_out_idle)
        else $error("finished and idle on the same tick");

    // times only reported for a completed entry
    a_times_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_edone) |->
        ((r_out_ct == '0) && (r_out_tat == '0) && (r_out_wt == '0)))
        else $error("times reported for an unfinished entry");

    // turnaround and waiting never exceed completion
    a_time_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_tat <= r_out_ct) && (r_out_wt <= r_out_tat)))
        else $error("turnaround or waiting above completion");

endmodule
